/* src/assert_macros.svh */
// Assertion macros shared by the query unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PQS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pqs assertion failed");

// Next-cycle implication, checked out of reset.
`define PQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pqs assertion failed");

`endif

/* src/pqs_pkg.sv */
// Types and constants of the point-to-segment query unit.
`default_nettype none
package pqs_pkg;

    localparam int COORD_W   = 16;
    localparam int DIFF_W    = 17;
    localparam int PROD_W    = 34;
    localparam int DOT_W     = 35;
    localparam int MAG_W     = 34;
    localparam int HALF_W    = 17;
    localparam int SQ_W      = 34;
    localparam int TOL_W     = 34;
    localparam int REM_W     = 52;
    localparam int QUO_W     = 18;
    localparam int SR_W      = 76;
    localparam int ST_W      = 56;
    localparam int NCELL     = 18;
    localparam int FRAC_W    = 17;
    localparam int DIST_W    = 20;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 34;
    localparam logic [FRAC_W-1:0] FRACTION_ONE = 17'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X  = 3'd0,
        CFG_START_Y  = 3'd1,
        CFG_END_X    = 3'd2,
        CFG_END_Y    = 3'd3,
        CFG_ON_TOL   = 3'd4
    } t_pqs_cfg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } t_pqs_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] closest_x;
        logic signed [COORD_W-1:0] closest_y;
        logic signed [COORD_W-1:0] proj_x;
        logic signed [COORD_W-1:0] proj_y;
        logic [FRAC_W-1:0]         fraction;
        logic signed [DIST_W-1:0]  signed_dist;
        logic                      above;
        logic                      below;
        logic                      on_line;
        logic                      in_bounds;
        logic                      degenerate;
    } t_pqs_out;

    // per-item flags carried alongside the cell chain
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic dot_le0;
        logic dot_ge_sq;
        logic cross_pos;
        logic cross_neg;
        logic on_line;
        logic in_bnd;
    } t_pqs_side;

endpackage
`default_nettype wire

/* src/pqs_div_cell.sv */
// One restoring-division cell: resolves one quotient bit per cycle.
`default_nettype none
module pqs_div_cell #(
    parameter int BIT = 0
) (
    input  wire logic                         i_clk,
    input  wire logic [pqs_pkg::REM_W-1:0]    i_rem,
    input  wire logic [pqs_pkg::QUO_W-1:0]    i_quo,
    input  wire logic [pqs_pkg::SQ_W-1:0]     i_den,
    output logic      [pqs_pkg::REM_W-1:0]    o_rem,
    output logic      [pqs_pkg::QUO_W-1:0]    o_quo
);
    logic [pqs_pkg::REM_W-1:0] w_dsh;
    logic [pqs_pkg::REM_W-1:0] r_rem;
    logic [pqs_pkg::QUO_W-1:0] r_quo;

    assign w_dsh = pqs_pkg::REM_W'(i_den) << BIT;

    always_ff @(posedge i_clk) begin
        if (i_rem >= w_dsh) begin
            r_rem <= i_rem - w_dsh;
            r_quo <= i_quo | (pqs_pkg::QUO_W'(1) << BIT);
        end else begin
            r_rem <= i_rem;
            r_quo <= i_quo;
        end
    end

    assign o_rem = r_rem;
    assign o_quo = r_quo;
endmodule
`default_nettype wire

/* src/pqs_sqrt_cell.sv */
// One cell of the distance search: decides one bit of round(|cross| / sqrt(sq)).
`default_nettype none
module pqs_sqrt_cell #(
    parameter int BIT = 0
) (
    input  wire logic                         i_clk,
    input  wire logic [pqs_pkg::SR_W-1:0]     i_r,
    input  wire logic [pqs_pkg::ST_W-1:0]     i_t,
    input  wire logic [pqs_pkg::QUO_W-1:0]    i_m,
    input  wire logic [pqs_pkg::SQ_W-1:0]     i_s,
    output logic      [pqs_pkg::SR_W-1:0]     o_r,
    output logic      [pqs_pkg::ST_W-1:0]     o_t,
    output logic      [pqs_pkg::QUO_W-1:0]    o_m
);
    // r = 4c^2 - k^2*s, t = k*s, k = 2m-1; raising m by 2^BIT adds a = 2^(BIT+1) to k
    logic [pqs_pkg::SR_W-1:0] w_t_ext;
    logic [pqs_pkg::SR_W-1:0] w_s_ext;
    logic [pqs_pkg::SR_W-1:0] w_cand;
    logic [pqs_pkg::ST_W-1:0] w_s_t;
    logic [pqs_pkg::SR_W-1:0] r_r;
    logic [pqs_pkg::ST_W-1:0] r_t;
    logic [pqs_pkg::QUO_W-1:0] r_m;

    assign w_t_ext = {{(pqs_pkg::SR_W-pqs_pkg::ST_W){i_t[pqs_pkg::ST_W-1]}}, i_t};
    assign w_s_ext = pqs_pkg::SR_W'(i_s);
    assign w_cand  = i_r - (w_t_ext << (BIT + 2)) - (w_s_ext << (2 * BIT + 2));
    assign w_s_t   = pqs_pkg::ST_W'(i_s) << (BIT + 1);

    always_ff @(posedge i_clk) begin
        if (!w_cand[pqs_pkg::SR_W-1]) begin
            r_r <= w_cand;
            r_t <= i_t + w_s_t;
            r_m <= i_m | (pqs_pkg::QUO_W'(1) << BIT);
        end else begin
            r_r <= i_r;
            r_t <= i_t;
            r_m <= i_m;
        end
    end

    assign o_r = r_r;
    assign o_t = r_t;
    assign o_m = r_m;
endmodule
`default_nettype wire

/* src/point_to_segment_query_unit.sv */
// Point-to-segment query unit: top level with front pipeline, cell chain and result stage.
//
//  channel   signals                          transaction when
//  -------   -------------------------------  ------------------------------
//  command   start, busy, i_point             start && !busy at clock edge
//  result    o_done, o_result                 o_done high, one cycle
//  config    i_cfg_valid, o_cfg_ready,        i_cfg_valid && o_cfg_ready
//            i_cfg_index, i_cfg_data
//
//  One point per cycle; each result passes through 5 front stages, a chain of 18
//  division/root cells and the output register.
//  busy is low whenever reset is released; results cannot be stalled.
//  Reset (i_rst_n, synchronous) clears the pipeline valids and config registers.
//  Derived segment terms settle through the r_dxx/r_dyy and r_sq registers after a config write.
`default_nettype none
`include "assert_macros.svh"
module point_to_segment_query_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire pqs_pkg::t_pqs_in                  i_point,
    output logic                                   o_done,
    output pqs_pkg::t_pqs_out                      o_result,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [pqs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [pqs_pkg::CFG_DAT_W-1:0]     i_cfg_data
);
    localparam int NC = pqs_pkg::NCELL;
    localparam int CW = pqs_pkg::COORD_W;
    localparam int QW = pqs_pkg::QUO_W;

    // configuration
    logic signed [CW-1:0]           r_start_x, r_start_y, r_end_x, r_end_y;
    logic [pqs_pkg::TOL_W-1:0]      r_tol;

    assign o_cfg_ready = 1'b1;
    assign busy        = !i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
            r_end_x   <= '0;
            r_end_y   <= '0;
            r_tol     <= '0;
        end else if (i_cfg_valid) begin
            unique case (pqs_pkg::t_pqs_cfg_idx'(i_cfg_index))
                pqs_pkg::CFG_START_X: r_start_x <= i_cfg_data[CW-1:0];
                pqs_pkg::CFG_START_Y: r_start_y <= i_cfg_data[CW-1:0];
                pqs_pkg::CFG_END_X:   r_end_x   <= i_cfg_data[CW-1:0];
                pqs_pkg::CFG_END_Y:   r_end_y   <= i_cfg_data[CW-1:0];
                pqs_pkg::CFG_ON_TOL:  r_tol     <= i_cfg_data[pqs_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // segment terms
    logic signed [pqs_pkg::DIFF_W-1:0] w_dx, w_dy;
    logic [CW-1:0]                     w_dx_mag, w_dy_mag;
    logic signed [pqs_pkg::PROD_W-1:0] w_dx2, w_dy2;
    logic [pqs_pkg::PROD_W-1:0]        r_dxx, r_dyy;
    logic [pqs_pkg::SQ_W-1:0]          r_sq;
    logic                              w_degen;

    assign w_dx     = pqs_pkg::DIFF_W'(r_end_x) - pqs_pkg::DIFF_W'(r_start_x);
    assign w_dy     = pqs_pkg::DIFF_W'(r_end_y) - pqs_pkg::DIFF_W'(r_start_y);
    assign w_dx_mag = w_dx[pqs_pkg::DIFF_W-1] ? CW'(-w_dx) : CW'(w_dx);
    assign w_dy_mag = w_dy[pqs_pkg::DIFF_W-1] ? CW'(-w_dy) : CW'(w_dy);
    assign w_dx2    = w_dx * w_dx;
    assign w_dy2    = w_dy * w_dy;
    assign w_degen  = (w_dx == '0) && (w_dy == '0);

    always_ff @(posedge i_clk) begin
        r_dxx <= w_dx2;
        r_dyy <= w_dy2;
        r_sq  <= r_dxx + r_dyy;
    end

    // stage 1: offsets from start
    logic                              r_v1;
    logic signed [pqs_pkg::DIFF_W-1:0] r_px1, r_py1;
    logic signed [pqs_pkg::DIFF_W-1:0] w_px, w_py;

    assign w_px = pqs_pkg::DIFF_W'(i_point.point_x) - pqs_pkg::DIFF_W'(r_start_x);
    assign w_py = pqs_pkg::DIFF_W'(i_point.point_y) - pqs_pkg::DIFF_W'(r_start_y);

    always_ff @(posedge i_clk) begin
        r_px1 <= w_px;
        r_py1 <= w_py;
    end

    // stage 2: products
    logic                              r_v2;
    logic signed [pqs_pkg::PROD_W-1:0] w_pxdx, w_pydy, w_dxpy, w_dypx;
    logic signed [pqs_pkg::PROD_W-1:0] r_pxdx, r_pydy, r_dxpy, r_dypx;

    assign w_pxdx = r_px1 * w_dx;
    assign w_pydy = r_py1 * w_dy;
    assign w_dxpy = w_dx * r_py1;
    assign w_dypx = w_dy * r_px1;

    always_ff @(posedge i_clk) begin
        r_pxdx <= w_pxdx;
        r_pydy <= w_pydy;
        r_dxpy <= w_dxpy;
        r_dypx <= w_dypx;
    end

    // stage 3: dot and cross
    logic                             r_v3;
    logic signed [pqs_pkg::DOT_W-1:0] w_dot, w_cross, r_dot3, r_cross3;

    assign w_dot   = pqs_pkg::DOT_W'(r_pxdx) + pqs_pkg::DOT_W'(r_pydy);
    assign w_cross = pqs_pkg::DOT_W'(r_dxpy) - pqs_pkg::DOT_W'(r_dypx);

    always_ff @(posedge i_clk) begin
        r_dot3   <= w_dot;
        r_cross3 <= w_cross;
    end

    // stage 4: numerator partial products and flags
    localparam int HW = pqs_pkg::HALF_W;
    logic                         r_v4;
    logic [pqs_pkg::MAG_W-1:0]    w_dot_mag, w_cr_mag, w_dotf, r_dotf;
    logic [CW+HW-1:0]             w_xh, w_xl, w_yh, w_yl, r_xh, r_xl, r_yh, r_yl;
    logic [2*HW-1:0]              w_chh, w_chl, w_cll, r_chh, r_chl, r_cll;
    pqs_pkg::t_pqs_side           w_side, r_side4;

    assign w_dot_mag = r_dot3[pqs_pkg::DOT_W-1] ? pqs_pkg::MAG_W'(-r_dot3)
                                                : pqs_pkg::MAG_W'(r_dot3);
    assign w_cr_mag  = r_cross3[pqs_pkg::DOT_W-1] ? pqs_pkg::MAG_W'(-r_cross3)
                                                  : pqs_pkg::MAG_W'(r_cross3);
    assign w_xh  = w_dx_mag * w_dot_mag[2*HW-1:HW];
    assign w_xl  = w_dx_mag * w_dot_mag[HW-1:0];
    assign w_yh  = w_dy_mag * w_dot_mag[2*HW-1:HW];
    assign w_yl  = w_dy_mag * w_dot_mag[HW-1:0];
    assign w_chh = w_cr_mag[2*HW-1:HW] * w_cr_mag[2*HW-1:HW];
    assign w_chl = w_cr_mag[2*HW-1:HW] * w_cr_mag[HW-1:0];
    assign w_cll = w_cr_mag[HW-1:0] * w_cr_mag[HW-1:0];

    always_comb begin
        w_side.neg_x     = w_dx[pqs_pkg::DIFF_W-1] ^ r_dot3[pqs_pkg::DOT_W-1];
        w_side.neg_y     = w_dy[pqs_pkg::DIFF_W-1] ^ r_dot3[pqs_pkg::DOT_W-1];
        w_side.dot_le0   = r_dot3[pqs_pkg::DOT_W-1] || (r_dot3 == '0);
        w_side.dot_ge_sq = !r_dot3[pqs_pkg::DOT_W-1] && (w_dot_mag >= r_sq);
        w_side.cross_neg = r_cross3[pqs_pkg::DOT_W-1];
        w_side.cross_pos = !r_cross3[pqs_pkg::DOT_W-1] && (r_cross3 != '0);
        w_side.on_line   = (w_cr_mag <= r_tol);
        w_side.in_bnd    = !w_side.dot_le0 && !w_side.dot_ge_sq;
        // fraction divider only sees in-range dots, keeps its quotient in 17 bits
        w_dotf           = w_side.in_bnd ? w_dot_mag : '0;
    end

    always_ff @(posedge i_clk) begin
        r_xh    <= w_xh;
        r_xl    <= w_xl;
        r_yh    <= w_yh;
        r_yl    <= w_yl;
        r_chh   <= w_chh;
        r_chl   <= w_chl;
        r_cll   <= w_cll;
        r_dotf  <= w_dotf;
        r_side4 <= w_side;
    end

    // stage 5: rounded numerators and root search start (k = -1)
    localparam int RW = pqs_pkg::REM_W;
    localparam int SW = pqs_pkg::SR_W;
    localparam int TW = pqs_pkg::ST_W;
    logic [RW-1:0]   w_sq_half;
    logic [2*pqs_pkg::PROD_W+1:0] w_c2;
    logic [SW-1:0]   w_c4;

    logic [RW-1:0]   w_rem_x [0:NC];
    logic [RW-1:0]   w_rem_y [0:NC];
    logic [RW-1:0]   w_rem_f [0:NC];
    logic [QW-1:0]   w_quo_x [0:NC];
    logic [QW-1:0]   w_quo_y [0:NC];
    logic [QW-1:0]   w_quo_f [0:NC];
    logic [SW-1:0]   w_sr    [0:NC];
    logic [TW-1:0]   w_st    [0:NC];
    logic [QW-1:0]   w_sm    [0:NC];

    logic [RW-1:0]   r_rem_x5, r_rem_y5, r_rem_f5;
    logic [SW-1:0]   r_sr5;
    logic [TW-1:0]   r_st5;

    assign w_sq_half = RW'(r_sq >> 1);
    assign w_c2 = ((2*pqs_pkg::PROD_W+2)'(r_chh) << (2*HW))
                + ((2*pqs_pkg::PROD_W+2)'(r_chl) << (HW+1))
                + (2*pqs_pkg::PROD_W+2)'(r_cll);
    assign w_c4 = SW'(w_c2) << 2;

    always_ff @(posedge i_clk) begin
        r_rem_x5 <= (RW'(r_xh) << HW) + RW'(r_xl) + w_sq_half;
        r_rem_y5 <= (RW'(r_yh) << HW) + RW'(r_yl) + w_sq_half;
        r_rem_f5 <= (RW'(r_dotf) << 16) + w_sq_half;
        r_sr5    <= w_c4 - SW'(r_sq);
        r_st5    <= TW'(0) - TW'(r_sq);
    end

    assign w_rem_x[0] = r_rem_x5;
    assign w_rem_y[0] = r_rem_y5;
    assign w_rem_f[0] = r_rem_f5;
    assign w_quo_x[0] = '0;
    assign w_quo_y[0] = '0;
    assign w_quo_f[0] = '0;
    assign w_sr[0]    = r_sr5;
    assign w_st[0]    = r_st5;
    assign w_sm[0]    = '0;

    // cell chain, most significant bit first
    for (genvar k = 0; k < NC; k++) begin : g_cell
        pqs_div_cell #(.BIT(NC - 1 - k)) u_div_x (
            .i_clk(i_clk), .i_rem(w_rem_x[k]), .i_quo(w_quo_x[k]), .i_den(r_sq),
            .o_rem(w_rem_x[k+1]), .o_quo(w_quo_x[k+1])
        );
        pqs_div_cell #(.BIT(NC - 1 - k)) u_div_y (
            .i_clk(i_clk), .i_rem(w_rem_y[k]), .i_quo(w_quo_y[k]), .i_den(r_sq),
            .o_rem(w_rem_y[k+1]), .o_quo(w_quo_y[k+1])
        );
        pqs_div_cell #(.BIT(NC - 1 - k)) u_div_f (
            .i_clk(i_clk), .i_rem(w_rem_f[k]), .i_quo(w_quo_f[k]), .i_den(r_sq),
            .o_rem(w_rem_f[k+1]), .o_quo(w_quo_f[k+1])
        );
        pqs_sqrt_cell #(.BIT(NC - 1 - k)) u_sqrt (
            .i_clk(i_clk), .i_r(w_sr[k]), .i_t(w_st[k]), .i_m(w_sm[k]), .i_s(r_sq),
            .o_r(w_sr[k+1]), .o_t(w_st[k+1]), .o_m(w_sm[k+1])
        );
    end

    // flags and valids travel beside the chain
    pqs_pkg::t_pqs_side r_side_d [0:NC];
    logic [NC:0]        r_vd;

    always_ff @(posedge i_clk) begin
        r_side_d[0] <= r_side4;
        for (int i = 1; i <= NC; i++) begin
            r_side_d[i] <= r_side_d[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_vd   <= '0;
            o_done <= 1'b0;
        end else begin
            r_v1   <= start && !busy;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_v4   <= r_v3;
            r_vd   <= {r_vd[NC-1:0], r_v4};
            o_done <= r_vd[NC];
        end
    end

    // result stage
    pqs_pkg::t_pqs_side w_sd;
    logic [QW:0]        w_qx, w_qy;
    logic [CW+3:0]      w_jx, w_jy;
    logic [CW-1:0]      w_jx_sat, w_jy_sat;
    pqs_pkg::t_pqs_out  w_res;

    assign w_sd = r_side_d[NC];
    assign w_qx = w_sd.neg_x ? (QW+1)'(0) - {1'b0, w_quo_x[NC]} : {1'b0, w_quo_x[NC]};
    assign w_qy = w_sd.neg_y ? (QW+1)'(0) - {1'b0, w_quo_y[NC]} : {1'b0, w_quo_y[NC]};
    assign w_jx = {{4{r_start_x[CW-1]}}, r_start_x} + {w_qx[QW], w_qx};
    assign w_jy = {{4{r_start_y[CW-1]}}, r_start_y} + {w_qy[QW], w_qy};

    always_comb begin
        if (!w_jx[CW+3] && (w_jx[CW+2:CW-1] != 4'h0)) begin
            w_jx_sat = {1'b0, {(CW-1){1'b1}}};
        end else if (w_jx[CW+3] && (w_jx[CW+2:CW-1] != 4'hF)) begin
            w_jx_sat = {1'b1, {(CW-1){1'b0}}};
        end else begin
            w_jx_sat = w_jx[CW-1:0];
        end
        if (!w_jy[CW+3] && (w_jy[CW+2:CW-1] != 4'h0)) begin
            w_jy_sat = {1'b0, {(CW-1){1'b1}}};
        end else if (w_jy[CW+3] && (w_jy[CW+2:CW-1] != 4'hF)) begin
            w_jy_sat = {1'b1, {(CW-1){1'b0}}};
        end else begin
            w_jy_sat = w_jy[CW-1:0];
        end

        w_res.above      = w_sd.cross_pos;
        w_res.below      = w_sd.cross_neg;
        w_res.on_line    = w_sd.on_line;
        w_res.in_bounds  = w_sd.in_bnd && !w_degen;
        w_res.degenerate = w_degen;

        if (w_degen) begin
            w_res.closest_x   = r_start_x;
            w_res.closest_y   = r_start_y;
            w_res.proj_x      = r_start_x;
            w_res.proj_y      = r_start_y;
            w_res.fraction    = '0;
            w_res.signed_dist = '0;
        end else begin
            w_res.proj_x = w_jx_sat;
            w_res.proj_y = w_jy_sat;
            if (w_sd.dot_le0) begin
                w_res.closest_x = r_start_x;
                w_res.closest_y = r_start_y;
                w_res.fraction  = '0;
            end else if (w_sd.dot_ge_sq) begin
                w_res.closest_x = r_end_x;
                w_res.closest_y = r_end_y;
                w_res.fraction  = pqs_pkg::FRACTION_ONE;
            end else begin
                w_res.closest_x = w_jx[CW-1:0];
                w_res.closest_y = w_jy[CW-1:0];
                w_res.fraction  = w_quo_f[NC][pqs_pkg::FRAC_W-1:0];
            end
            // distance stays below 2^17, inside the 20-bit range
            w_res.signed_dist = w_sd.cross_neg
                ? pqs_pkg::DIST_W'(0) - pqs_pkg::DIST_W'(w_sm[NC])
                : pqs_pkg::DIST_W'(w_sm[NC]);
        end
    end

    always_ff @(posedge i_clk) begin
        o_result <= w_res;
    end

    `PQS_ASSERT_IMPL(a_side_excl, i_clk, i_rst_n, o_done, !(o_result.above && o_result.below))
    `PQS_ASSERT_IMPL(a_frac_range, i_clk, i_rst_n, o_done, o_result.fraction <= pqs_pkg::FRACTION_ONE)
    `PQS_ASSERT_IMPL(a_degen_zero, i_clk, i_rst_n, o_done && o_result.degenerate, (o_result.fraction == '0) && (o_result.signed_dist == '0) && !o_result.in_bounds)
    `PQS_ASSERT_NEXT(a_cmd_tracked, i_clk, i_rst_n, start && !busy, r_v1)
endmodule
`default_nettype wire

/* tb/point_to_segment_query_checker.sv */
// Checker for the point-to-segment query unit: tracks config, predicts and compares results.
`timescale 1ns / 1ps
`default_nettype none
module point_to_segment_query_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic                          i_busy,
    input  wire pqs_pkg::t_pqs_in              i_point,
    input  wire logic                          i_done,
    input  wire pqs_pkg::t_pqs_out             i_result,
    input  wire logic                          i_cfg_valid,
    input  wire logic                          i_cfg_ready,
    input  wire logic [pqs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [pqs_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output int                                 o_errors,
    output int                                 o_pending
);
    logic signed [pqs_pkg::COORD_W-1:0] seg_sx, seg_sy, seg_ex, seg_ey;
    logic [pqs_pkg::TOL_W-1:0]          seg_tol;
    pqs_pkg::t_pqs_out                  expected_results[$];

    function automatic longint round_div(longint num, longint den);
        longint q;
        q = ((num < 0 ? -num : num) + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    function automatic longint clip(longint v, int w);
        longint hi, lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    // |cross| / sqrt(sq), rounded half up, by bisection on (2c)^2 >= (2m-1)^2 * sq
    function automatic longint dist_magnitude(longint c, longint s);
        logic [127:0] c2, t;
        longint lo, hi, mid, k;
        c2 = 128'(2 * c) * 128'(2 * c);
        lo = 0;
        hi = longint'(1) <<< 21;
        while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            k = 2 * mid - 1;
            t = 128'(k * k) * 128'(s);
            if (t <= c2) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic pqs_pkg::t_pqs_out predict_query(pqs_pkg::t_pqs_in p);
        longint sx, sy, ex, ey, dx, dy, px, py, dotp, crs, sqr, cx, cy, jx, jy, sdist, frac, m;
        pqs_pkg::t_pqs_out r;
        sx = seg_sx; sy = seg_sy; ex = seg_ex; ey = seg_ey;
        dx = ex - sx; dy = ey - sy;
        px = longint'(p.point_x) - sx;
        py = longint'(p.point_y) - sy;
        dotp = px * dx + py * dy;
        crs = dx * py - dy * px;
        sqr = dx * dx + dy * dy;
        sdist = 0;
        frac = 0;
        if (sqr == 0) begin
            cx = sx; cy = sy; jx = sx; jy = sy;
        end else begin
            jx = clip(sx + round_div(dx * dotp, sqr), pqs_pkg::COORD_W);
            jy = clip(sy + round_div(dy * dotp, sqr), pqs_pkg::COORD_W);
            if (dotp <= 0) begin
                cx = sx; cy = sy;
            end else if (dotp >= sqr) begin
                cx = ex; cy = ey; frac = 65536;
            end else begin
                cx = sx + round_div(dx * dotp, sqr);
                cy = sy + round_div(dy * dotp, sqr);
                frac = round_div(dotp * 65536, sqr);
            end
            m = dist_magnitude(crs < 0 ? -crs : crs, sqr);
            sdist = clip(crs < 0 ? -m : m, pqs_pkg::DIST_W);
        end
        r.closest_x   = pqs_pkg::COORD_W'(cx);
        r.closest_y   = pqs_pkg::COORD_W'(cy);
        r.proj_x      = pqs_pkg::COORD_W'(jx);
        r.proj_y      = pqs_pkg::COORD_W'(jy);
        r.fraction    = pqs_pkg::FRAC_W'(frac);
        r.signed_dist = pqs_pkg::DIST_W'(sdist);
        r.above       = crs > 0;
        r.below       = crs < 0;
        r.on_line     = (crs < 0 ? -crs : crs) <= longint'({30'd0, seg_tol});
        r.in_bounds   = dotp > 0 && dotp < sqr;
        r.degenerate  = sqr == 0;
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        pqs_pkg::t_pqs_out want;
        int                delta;
        delta = 0;
        if (!i_rst_n) begin
            seg_sx <= '0; seg_sy <= '0; seg_ex <= '0; seg_ey <= '0; seg_tol <= '0;
            o_errors  <= 0;
            o_pending <= 0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    pqs_pkg::CFG_START_X: seg_sx <= i_cfg_data[pqs_pkg::COORD_W-1:0];
                    pqs_pkg::CFG_START_Y: seg_sy <= i_cfg_data[pqs_pkg::COORD_W-1:0];
                    pqs_pkg::CFG_END_X:   seg_ex <= i_cfg_data[pqs_pkg::COORD_W-1:0];
                    pqs_pkg::CFG_END_Y:   seg_ey <= i_cfg_data[pqs_pkg::COORD_W-1:0];
                    pqs_pkg::CFG_ON_TOL:  seg_tol <= i_cfg_data[pqs_pkg::TOL_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                expected_results.push_back(predict_query(i_point));
                delta = delta + 1;
            end
            if (i_done) begin
                if (expected_results.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result %p", i_result);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_results.pop_front();
                    delta = delta - 1;
                    if (i_result.closest_x !== want.closest_x
                        || i_result.closest_y !== want.closest_y
                        || i_result.proj_x !== want.proj_x
                        || i_result.proj_y !== want.proj_y
                        || i_result.fraction !== want.fraction
                        || i_result.signed_dist !== want.signed_dist
                        || i_result.above !== want.above
                        || i_result.below !== want.below
                        || i_result.on_line !== want.on_line
                        || i_result.in_bounds !== want.in_bounds
                        || i_result.degenerate !== want.degenerate) begin
                        if (o_errors < 10) begin
                            $display("mismatch: expected %p", want);
                            $display("          actual   %p", i_result);
                        end
                        o_errors <= o_errors + 1;
                    end
                end
            end
            // count of transactions still in flight
            o_pending <= o_pending + delta;
        end
    end
endmodule
`default_nettype wire

/* tb/point_to_segment_query_unit_test.sv */
// Testbench top for the point-to-segment query unit: stimulus, config phases and verdict.
`timescale 1ns / 1ps
`default_nettype none
module point_to_segment_query_unit_test;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN = 30;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    pqs_pkg::t_pqs_in              i_point = '0;
    logic                          o_done;
    pqs_pkg::t_pqs_out             o_result;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [pqs_pkg::CFG_IDX_W-1:0] i_cfg_index = pqs_pkg::CFG_START_X;
    logic [pqs_pkg::CFG_DAT_W-1:0] i_cfg_data = '0;
    int                            errors, pending, cycles = 0, idle_pct = 0;

    point_to_segment_query_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_point(i_point),
        .o_done(o_done), .o_result(o_result), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    point_to_segment_query_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy), .i_point(i_point),
        .i_done(o_done), .i_result(o_result), .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("point_to_segment_query_unit_test failed");
            $finish;
        end
    end

    // one edge first so the checker count includes the last transaction
    task automatic drain_pipe();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // leaves valid high; the caller drops it after the last write
    task automatic write_reg(input logic [pqs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pqs_pkg::CFG_DAT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // segment writes with junk in the unused upper data bits; then waits for derived terms to settle
    task automatic set_segment(input logic [15:0] sx, input logic [15:0] sy,
                               input logic [15:0] ex, input logic [15:0] ey,
                               input logic [33:0] tol);
        start <= 1'b0;
        drain_pipe();
        write_reg(pqs_pkg::CFG_START_X, {18'($urandom), sx});
        write_reg(pqs_pkg::CFG_START_Y, {18'($urandom), sy});
        write_reg(pqs_pkg::CFG_END_X, {18'($urandom), ex});
        write_reg(pqs_pkg::CFG_END_Y, {18'($urandom), ey});
        write_reg(pqs_pkg::CFG_ON_TOL, tol);
        i_cfg_valid <= 1'b0;
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_point(input logic [15:0] x, input logic [15:0] y);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_point <= '{point_x: x, point_y: y};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    function automatic logic [33:0] rand_tol();
        case ($urandom_range(3))
            0: return 34'($urandom_range(255));
            1: return {2'($urandom), 32'($urandom)};
            2: return 34'($urandom) >> $urandom_range(33);
            default: return '1;
        endcase
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed(10'($urandom)));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] sx, sy, ex, ey, px, py;
        int n;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset segment is zero length
        send_point(16'h7fff, 16'h8000);
        send_point(16'h0000, 16'h0000);

        set_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, '1);
        send_point(16'h8000, 16'h7fff);
        send_point(16'h7fff, 16'h8000);
        send_point(16'h8000, 16'h8000);
        send_point(16'h7fff, 16'h7fff);
        send_point(16'h0000, 16'h0000);
        send_point(16'h1234, 16'h1200);

        set_segment(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 34'd0);
        send_point(16'h8000, 16'h8000);
        send_point(16'h7fff, 16'h7fff);

        // horizontal segment: above, below, on line, both ends, outside each end
        set_segment(16'd0, 16'd0, 16'd160, 16'd0, 34'd0);
        send_point(16'd80, 16'd16);
        send_point(16'd80, -16'sd16);
        send_point(16'd80, 16'd0);
        send_point(16'd0, 16'd0);
        send_point(16'd160, 16'd0);
        send_point(-16'sd5, 16'd3);
        send_point(16'd200, 16'd1);
        send_point(16'd53, 16'd1);

        // short segment with points far from it
        set_segment(16'd0, 16'd0, 16'd1, 16'd1, 34'd300);
        send_point(16'h7fff, 16'h7fff);
        send_point(16'h8000, 16'h8000);
        send_point(16'h7fff, 16'h8000);

        // register index past the last one must be ignored
        start <= 1'b0;
        drain_pipe();
        write_reg(pqs_pkg::CFG_ON_TOL + 3'd1, '1);
        write_reg(pqs_pkg::CFG_ON_TOL + 3'd3, '1);
        i_cfg_valid <= 1'b0;
        repeat (4) @(posedge i_clk);
        send_point(16'd0, 16'd0);

        for (int phase = 0; phase < 9; phase++) begin
            case ($urandom_range(5))
                0: begin sx = rand_coord(); sy = rand_coord(); ex = sx; ey = sy; end
                1: begin
                    sx = rand_coord(); sy = rand_coord();
                    ex = sx + 16'($signed(4'($urandom))); ey = sy + 16'($signed(4'($urandom)));
                end
                default: begin
                    sx = rand_coord(); sy = rand_coord(); ex = rand_coord(); ey = rand_coord();
                end
            endcase
            set_segment(sx, sy, ex, ey, rand_tol());
            idle_pct = phase < 3 ? 30 : (phase < 6 ? 58 : 0);
            for (int i = 0; i < 160; i++) begin
                if (phase == 4 && i == 80) begin
                    start <= 1'b0;
                    drain_pipe();
                end
                case ($urandom_range(3))
                    0: begin px = rand_coord(); py = rand_coord(); end
                    default: begin
                        // near the line: start + t*d plus a small offset
                        n = $urandom_range(1200);
                        px = 16'(longint'($signed(sx)) + ((longint'($signed(ex)) -
                             longint'($signed(sx))) * n) / 1000 + $signed(5'($urandom)));
                        py = 16'(longint'($signed(sy)) + ((longint'($signed(ey)) -
                             longint'($signed(sy))) * n) / 1000 + $signed(5'($urandom)));
                    end
                endcase
                send_point(px, py);
            end
        end

        start <= 1'b0;
        drain_pipe();
        if (errors == 0 && pending == 0) begin
            $display("point_to_segment_query_unit_test passed");
        end else begin
            $display("point_to_segment_query_unit_test failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
